// ===== sv/assert_macros.svh =====
// shared assertion macros, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every edge
`define MFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/mfa_pkg.sv =====
package mfa_pkg;

  // operation codes, codes above OP_READ act as read
  localparam logic [2:0] OP_SET  = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_INC  = 3'd3;
  localparam logic [2:0] OP_DEC  = 3'd4;
  localparam logic [2:0] OP_READ = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // datapath micro operations
  typedef enum logic [4:0] {
    U_NONE, U_SET, U_ADDW, U_M_AN_Z, U_M_AD_Y, U_ADD_PN, U_M_AD_Z,
    U_MW0, U_M_AW_AD, U_ADD_PAN, U_M_X_Z, U_ADD_NY, U_M_P_N, U_M_Q_D,
    U_DIV_ND, U_CLRD, U_ZD, U_DIV_G, U_DIV_NG, U_DIV_DG,
    U_INC, U_DEC, U_RDCHK, U_COMMIT, U_OUT
  } uop_t;

  typedef struct packed {
    logic load;
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic n_zero;
    logic d_zero;
    logic an_zero;
    logic y_zero;
    logic gb_zero;
  } sts_t;

endpackage

// ===== sv/mfa_if.sv =====
// command channel
interface mfa_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        operation;
  logic signed [31:0] operand_whole;
  logic signed [31:0] operand_numer;
  logic signed [31:0] operand_denom;

  modport source (output valid, operation, operand_whole, operand_numer, operand_denom,
                  input ready);
  modport sink (input valid, operation, operand_whole, operand_numer, operand_denom,
                output ready);
endinterface

// result channel
interface mfa_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] value_whole;
  logic signed [31:0] value_numer;
  logic signed [31:0] value_denom;
  logic [1:0]        status;

  modport source (output valid, value_whole, value_numer, value_denom, status,
                  input ready);
  modport sink (input valid, value_whole, value_numer, value_denom, status,
                output ready);
endinterface

// ===== sv/mfa_mul.sv =====
`include "assert_macros.svh"

module mfa_mul #(
  parameter int WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [WIDTH-1:0] a,
  input  logic signed [WIDTH-1:0] b,
  output logic                    done,
  output logic signed [WIDTH-1:0] prod,
  output logic                    ovf
);

  localparam int CW = $clog2(WIDTH);
  localparam int PW = 2 * WIDTH;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] mc_r, mc_nxt;
  logic [WIDTH-1:0] mp_r, mp_nxt;
  logic [PW-1:0] acc_r, acc_nxt;
  logic          neg_r, neg_nxt;
  logic [WIDTH-1:0] ua, ub;
  logic [PW-1:0] sp, limit;

  // operand magnitudes
  assign ua = a[WIDTH-1] ? (~a + 1'b1) : a;
  assign ub = b[WIDTH-1] ? (~b + 1'b1) : b;

  // shift and add, one multiplier bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    acc_nxt  = acc_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(WIDTH - 1);
      mc_nxt   = {{WIDTH{1'b0}}, ua};
      mp_nxt   = ub;
      acc_nxt  = '0;
      neg_nxt  = a[WIDTH-1] ^ b[WIDTH-1];
    end else if (busy_r) begin
      if (mp_r[0]) begin
        acc_nxt = acc_r + mc_r;
      end
      mc_nxt = mc_r << 1;
      mp_nxt = mp_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
    acc_r <= acc_nxt;
    neg_r <= neg_nxt;
  end

  // signed result and range check
  assign sp    = neg_r ? (~acc_r + 1'b1) : acc_r;
  assign limit = (PW'(1) << (WIDTH - 1)) - PW'(1) + PW'(neg_r);
  assign prod  = sp[WIDTH-1:0];
  assign ovf   = acc_r > limit;
  assign done  = done_r;

  `MFA_ASSERT(a_mul_no_restart, !(start && busy_r), "multiplier started while busy")
  `MFA_ASSERT_NEXT(a_mul_done_pulse, done_r, !done_r, "multiplier done held two cycles")

endmodule

// ===== sv/mfa_div.sv =====
module mfa_div #(
  parameter int WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [WIDTH-1:0] a,
  input  logic signed [WIDTH-1:0] b,
  output logic                    done,
  output logic signed [WIDTH-1:0] quo,
  output logic signed [WIDTH-1:0] rem,
  output logic                    ovf
);

  localparam int CW = $clog2(WIDTH);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [WIDTH:0]   rem_r, rem_nxt;
  logic [WIDTH-1:0] quo_r, quo_nxt;
  logic [WIDTH-1:0] dv_r, dv_nxt;
  logic          sq_r, sq_nxt;
  logic          sr_r, sr_nxt;
  logic          ovf_r, ovf_nxt;
  logic [WIDTH-1:0] ua, ub;
  logic [WIDTH:0]   trial;

  assign ua = a[WIDTH-1] ? (~a + 1'b1) : a;
  assign ub = b[WIDTH-1] ? (~b + 1'b1) : b;
  assign trial = {rem_r[WIDTH-1:0], quo_r[WIDTH-1]};

  // restoring division, one quotient bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dv_nxt   = dv_r;
    sq_nxt   = sq_r;
    sr_nxt   = sr_r;
    ovf_nxt  = ovf_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(WIDTH - 1);
      rem_nxt  = '0;
      quo_nxt  = ua;
      dv_nxt   = ub;
      sq_nxt   = a[WIDTH-1] ^ b[WIDTH-1];
      sr_nxt   = a[WIDTH-1];
      ovf_nxt  = (a == {1'b1, {(WIDTH-1){1'b0}}}) && (b == {WIDTH{1'b1}});
    end else if (busy_r) begin
      if (trial >= {1'b0, dv_r}) begin
        rem_nxt = trial - {1'b0, dv_r};
        quo_nxt = {quo_r[WIDTH-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[WIDTH-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dv_r  <= dv_nxt;
    sq_r  <= sq_nxt;
    sr_r  <= sr_nxt;
    ovf_r <= ovf_nxt;
  end

  // truncating signs: quotient by both, remainder by dividend
  assign quo  = sq_r ? (~quo_r + 1'b1) : quo_r;
  assign rem  = sr_r ? (~rem_r[WIDTH-1:0] + 1'b1) : rem_r[WIDTH-1:0];
  assign ovf  = ovf_r;
  assign done = done_r;

endmodule

// ===== sv/mfa_dp.sv =====
`include "assert_macros.svh"

module mfa_dp
  import mfa_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [2:0]         in_op,
  input  logic signed [31:0] in_whole,
  input  logic signed [31:0] in_numer,
  input  logic signed [31:0] in_denom,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_whole,
  output logic signed [31:0] out_numer,
  output logic signed [31:0] out_denom,
  output logic [1:0]         out_status
);

  localparam logic signed [WIDTH-1:0] W_ONE  = WIDTH'(1);
  localparam logic signed [WIDTH-1:0] W_NEG1 = {WIDTH{1'b1}};

  typedef logic signed [WIDTH-1:0] word_t;

  word_t aw_r, aw_nxt, an_r, an_nxt, ad_r, ad_nxt;
  word_t x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  word_t w_r, w_nxt, n_r, n_nxt, d_r, d_nxt, p_r, p_nxt, q_r, q_nxt;
  word_t ga_r, ga_nxt, gb_r, gb_nxt;
  logic  ovf_r, ovf_nxt, zd_r, zd_nxt, busy_r, busy_nxt;
  logic  ov_r, ov_nxt;
  logic signed [31:0] ow_r, ow_nxt, on_r, on_nxt, od_r, od_nxt;
  logic [1:0] ost_r, ost_nxt;

  logic  is_mul, is_div, mul_done, div_done, mul_ovf, div_ovf;
  logic  done_c;
  word_t mul_a, mul_b, div_a, div_b, mul_prod, div_quo, div_rem;
  logic [WIDTH:0] fx, fy, fz;

  // wrapping add with overflow flag on top
  function automatic logic [WIDTH:0] add_w(word_t a, word_t b);
    word_t s;
    s = a + b;
    return {(a[WIDTH-1] == b[WIDTH-1]) && (s[WIDTH-1] != a[WIDTH-1]), s};
  endfunction

  // fit a 32 bit field into WIDTH bits
  function automatic logic [WIDTH:0] take_f(logic signed [31:0] f);
    logic signed [63:0] s;
    logic signed [63:0] e;
    word_t r;
    s = 64'(f);
    r = s[WIDTH-1:0];
    e = 64'(r);
    return {e != s, r};
  endfunction

  // low 32 bits of a sign extended value
  function automatic logic signed [31:0] to32(word_t v);
    logic signed [63:0] e;
    e = 64'(v);
    return e[31:0];
  endfunction

  assign fx = take_f(in_whole);
  assign fy = take_f(in_numer);
  assign fz = take_f(in_denom);

  // operand routing for the shared units
  always_comb begin
    is_mul = 1'b1;
    mul_a  = an_r;
    mul_b  = z_r;
    unique case (cmd.uop)
      U_M_AN_Z:  begin mul_a = an_r; mul_b = z_r;  end
      U_M_AD_Y:  begin mul_a = ad_r; mul_b = y_r;  end
      U_M_AD_Z:  begin mul_a = ad_r; mul_b = z_r;  end
      U_M_AW_AD: begin mul_a = aw_r; mul_b = ad_r; end
      U_M_X_Z:   begin mul_a = x_r;  mul_b = z_r;  end
      U_M_P_N:   begin mul_a = p_r;  mul_b = n_r;  end
      U_M_Q_D:   begin mul_a = q_r;  mul_b = d_r;  end
      default:   is_mul = 1'b0;
    endcase
  end

  always_comb begin
    is_div = 1'b1;
    div_a  = n_r;
    div_b  = d_r;
    unique case (cmd.uop)
      U_DIV_ND: begin div_a = n_r;  div_b = d_r;  end
      U_DIV_G:  begin div_a = ga_r; div_b = gb_r; end
      U_DIV_NG: begin div_a = n_r;  div_b = ga_r; end
      U_DIV_DG: begin div_a = d_r;  div_b = ga_r; end
      default:  is_div = 1'b0;
    endcase
  end

  mfa_mul #(.WIDTH(WIDTH)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(is_mul && !busy_r), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_prod), .ovf(mul_ovf)
  );

  mfa_div #(.WIDTH(WIDTH)) u_div (
    .clk(clk), .rst_n(rst_n), .start(is_div && !busy_r), .a(div_a), .b(div_b),
    .done(div_done), .quo(div_quo), .rem(div_rem), .ovf(div_ovf)
  );

  // micro operation execution
  always_comb begin
    logic  av;
    word_t asum;
    aw_nxt = aw_r; an_nxt = an_r; ad_nxt = ad_r;
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r;
    w_nxt = w_r; n_nxt = n_r; d_nxt = d_r; p_nxt = p_r; q_nxt = q_r;
    ga_nxt = ga_r; gb_nxt = gb_r;
    ovf_nxt = ovf_r; zd_nxt = zd_r;
    busy_nxt = busy_r;
    ow_nxt = ow_r; on_nxt = on_r; od_nxt = od_r; ost_nxt = ost_r;
    ov_nxt = ov_r;
    av = 1'b0;
    asum = '0;
    done_c = 1'b0;

    // capture a new command transaction
    if (cmd.load) begin
      x_nxt  = fx[WIDTH-1:0];
      y_nxt  = fy[WIDTH-1:0];
      z_nxt  = fz[WIDTH-1:0];
      ovf_nxt = (in_op == OP_SET || in_op == OP_ADD || in_op == OP_MUL) &&
                (fx[WIDTH] || fy[WIDTH] || fz[WIDTH]);
      zd_nxt = 1'b0;
    end

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    // unit start bookkeeping
    if ((is_mul || is_div) && !busy_r) begin
      busy_nxt = 1'b1;
    end
    if (mul_done || div_done) begin
      busy_nxt = 1'b0;
    end

    unique case (cmd.uop)
      U_NONE: done_c = 1'b1;
      U_SET: begin
        w_nxt = x_r; n_nxt = y_r; d_nxt = z_r;
        done_c = 1'b1;
      end
      U_ADDW: begin
        {av, asum} = add_w(aw_r, x_r);
        w_nxt = asum;
        if (an_r == '0) begin
          n_nxt = y_r; d_nxt = z_r;
        end else begin
          n_nxt = an_r; d_nxt = ad_r;
        end
        done_c = 1'b1;
      end
      U_M_AN_Z: begin
        done_c = mul_done;
        if (mul_done) p_nxt = mul_prod;
      end
      U_M_AD_Y, U_M_X_Z, U_M_P_N: begin
        done_c = mul_done;
        if (mul_done) n_nxt = mul_prod;
      end
      U_M_AD_Z, U_M_Q_D: begin
        done_c = mul_done;
        if (mul_done) d_nxt = mul_prod;
      end
      U_M_AW_AD: begin
        done_c = mul_done;
        if (mul_done) p_nxt = mul_prod;
      end
      U_ADD_PN: begin
        {av, asum} = add_w(p_r, n_r);
        n_nxt = asum;
        done_c = 1'b1;
      end
      U_MW0: begin
        w_nxt = '0;
        if (an_r == '0) begin
          p_nxt = aw_r; q_nxt = W_ONE;
        end else begin
          q_nxt = ad_r;
        end
        if (y_r == '0) begin
          n_nxt = x_r; d_nxt = W_ONE;
        end else begin
          d_nxt = z_r;
        end
        done_c = 1'b1;
      end
      U_ADD_PAN: begin
        {av, asum} = add_w(p_r, an_r);
        p_nxt = asum;
        done_c = 1'b1;
      end
      U_ADD_NY: begin
        {av, asum} = add_w(n_r, y_r);
        n_nxt = asum;
        done_c = 1'b1;
      end
      U_DIV_ND: begin
        done_c = div_done;
        if (div_done) begin
          {av, asum} = add_w(w_r, div_quo);
          w_nxt  = asum;
          n_nxt  = div_rem;
          ga_nxt = d_r;
          gb_nxt = div_rem;
        end
      end
      U_CLRD: begin
        d_nxt = '0;
        done_c = 1'b1;
      end
      U_ZD: begin
        zd_nxt = 1'b1;
        done_c = 1'b1;
      end
      U_DIV_G: begin
        done_c = div_done;
        if (div_done) begin
          ga_nxt = gb_r;
          gb_nxt = div_rem;
        end
      end
      U_DIV_NG: begin
        done_c = div_done;
        if (div_done) n_nxt = div_quo;
      end
      U_DIV_DG: begin
        done_c = div_done;
        if (div_done) d_nxt = div_quo;
      end
      U_INC: begin
        {av, asum} = add_w(aw_r, W_ONE);
        aw_nxt = asum;
        done_c = 1'b1;
      end
      U_DEC: begin
        {av, asum} = add_w(aw_r, W_NEG1);
        aw_nxt = asum;
        done_c = 1'b1;
      end
      U_RDCHK: begin
        zd_nxt = (an_r != '0) && (ad_r == '0);
        done_c = 1'b1;
      end
      U_COMMIT: begin
        aw_nxt = w_r; an_nxt = n_r; ad_nxt = d_r;
        done_c = 1'b1;
      end
      U_OUT: begin
        if (!ov_r || out_ready) begin
          ow_nxt = to32(aw_r);
          on_nxt = to32(an_r);
          od_nxt = to32(ad_r);
          ost_nxt = zd_r ? ST_ZERO_DEN : (ovf_r ? ST_OVERFLOW : ST_OK);
          ov_nxt = 1'b1;
          done_c = 1'b1;
        end
      end
      default: done_c = 1'b1;
    endcase

    // fold in overflow from adds and finished units
    ovf_nxt = ovf_nxt | av | (mul_done && mul_ovf) | (div_done && div_ovf);
  end

  // flags for the sequencer
  assign sts = '{done:    done_c,
                 n_zero:  (n_r == '0),
                 d_zero:  (d_r == '0),
                 an_zero: (an_r == '0),
                 y_zero:  (y_r == '0),
                 gb_zero: (gb_r == '0)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aw_r   <= '0;
      an_r   <= '0;
      ad_r   <= '0;
      ovf_r  <= 1'b0;
      zd_r   <= 1'b0;
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      aw_r   <= aw_nxt;
      an_r   <= an_nxt;
      ad_r   <= ad_nxt;
      ovf_r  <= ovf_nxt;
      zd_r   <= zd_nxt;
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt;
    w_r <= w_nxt; n_r <= n_nxt; d_r <= d_nxt; p_r <= p_nxt; q_r <= q_nxt;
    ga_r <= ga_nxt; gb_r <= gb_nxt;
    ow_r <= ow_nxt; on_r <= on_nxt; od_r <= od_nxt; ost_r <= ost_nxt;
  end

  assign out_valid  = ov_r;
  assign out_whole  = ow_r;
  assign out_numer  = on_r;
  assign out_denom  = od_r;
  assign out_status = ost_r;

  `MFA_ASSERT(a_zd_denom_zero, !(ov_r && ost_r == ST_ZERO_DEN) || od_r == '0,
              "zero denominator result with nonzero denominator")
  `MFA_ASSERT(a_zd_commit, !(cmd.uop == U_COMMIT && zd_r) || d_r == '0,
              "faulted value committed with nonzero denominator")

endmodule

// ===== sv/mfa_ctrl.sv =====
`include "assert_macros.svh"

module mfa_ctrl
  import mfa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_op,
  input  sts_t       sts,
  output cmd_t       cmd
);

  typedef enum logic [27:0] {
    ST_IDLE   = 28'h0000001,
    ST_SET    = 28'h0000002,
    ST_ADDW   = 28'h0000004,
    ST_A_M1   = 28'h0000008,
    ST_A_M2   = 28'h0000010,
    ST_A_ADD  = 28'h0000020,
    ST_A_M3   = 28'h0000040,
    ST_MW0    = 28'h0000080,
    ST_M_AWAD = 28'h0000100,
    ST_M_ADDP = 28'h0000200,
    ST_M_XZ   = 28'h0000400,
    ST_M_ADDN = 28'h0000800,
    ST_M_PN   = 28'h0001000,
    ST_M_QD   = 28'h0002000,
    ST_N_CHK  = 28'h0004000,
    ST_N_CLRD = 28'h0008000,
    ST_N_ZD   = 28'h0010000,
    ST_N_DIV  = 28'h0020000,
    ST_N_CHK2 = 28'h0040000,
    ST_G_CHK  = 28'h0080000,
    ST_G_STEP = 28'h0100000,
    ST_G_NG   = 28'h0200000,
    ST_G_DG   = 28'h0400000,
    ST_INC    = 28'h0800000,
    ST_DEC    = 28'h1000000,
    ST_RD     = 28'h2000000,
    ST_COMMIT = 28'h4000000,
    ST_OUT    = 28'h8000000
  } state_t;

  state_t state_r, state_nxt;
  uop_t   uop_c;

  assign in_ready = (state_r == ST_IDLE);
  assign cmd = '{load: in_valid && in_ready, uop: uop_c};

  // micro operation per state
  always_comb begin
    unique case (state_r)
      ST_SET:    uop_c = U_SET;
      ST_ADDW:   uop_c = U_ADDW;
      ST_A_M1:   uop_c = U_M_AN_Z;
      ST_A_M2:   uop_c = U_M_AD_Y;
      ST_A_ADD:  uop_c = U_ADD_PN;
      ST_A_M3:   uop_c = U_M_AD_Z;
      ST_MW0:    uop_c = U_MW0;
      ST_M_AWAD: uop_c = U_M_AW_AD;
      ST_M_ADDP: uop_c = U_ADD_PAN;
      ST_M_XZ:   uop_c = U_M_X_Z;
      ST_M_ADDN: uop_c = U_ADD_NY;
      ST_M_PN:   uop_c = U_M_P_N;
      ST_M_QD:   uop_c = U_M_Q_D;
      ST_N_CLRD: uop_c = U_CLRD;
      ST_N_ZD:   uop_c = U_ZD;
      ST_N_DIV:  uop_c = U_DIV_ND;
      ST_G_STEP: uop_c = U_DIV_G;
      ST_G_NG:   uop_c = U_DIV_NG;
      ST_G_DG:   uop_c = U_DIV_DG;
      ST_INC:    uop_c = U_INC;
      ST_DEC:    uop_c = U_DEC;
      ST_RD:     uop_c = U_RDCHK;
      ST_COMMIT: uop_c = U_COMMIT;
      ST_OUT:    uop_c = U_OUT;
      default:   uop_c = U_NONE;
    endcase
  end

  // sequencing
  always_comb begin
    state_nxt = state_r;
    if (state_r == ST_IDLE) begin
      if (in_valid) begin
        unique case (in_op)
          OP_SET:  state_nxt = ST_SET;
          OP_ADD:  state_nxt = ST_ADDW;
          OP_MUL:  state_nxt = ST_MW0;
          OP_INC:  state_nxt = ST_INC;
          OP_DEC:  state_nxt = ST_DEC;
          default: state_nxt = ST_RD;
        endcase
      end
    end else if (sts.done) begin
      unique case (state_r)
        ST_SET:    state_nxt = ST_N_CHK;
        ST_ADDW:   state_nxt = (!sts.an_zero && !sts.y_zero) ? ST_A_M1 : ST_N_CHK;
        ST_A_M1:   state_nxt = ST_A_M2;
        ST_A_M2:   state_nxt = ST_A_ADD;
        ST_A_ADD:  state_nxt = ST_A_M3;
        ST_A_M3:   state_nxt = ST_N_CHK;
        ST_MW0: begin
          priority if (!sts.an_zero) state_nxt = ST_M_AWAD;
          else if (!sts.y_zero)      state_nxt = ST_M_XZ;
          else                       state_nxt = ST_M_PN;
        end
        ST_M_AWAD: state_nxt = ST_M_ADDP;
        ST_M_ADDP: state_nxt = sts.y_zero ? ST_M_PN : ST_M_XZ;
        ST_M_XZ:   state_nxt = ST_M_ADDN;
        ST_M_ADDN: state_nxt = ST_M_PN;
        ST_M_PN:   state_nxt = ST_M_QD;
        ST_M_QD:   state_nxt = ST_N_CHK;
        ST_N_CHK: begin
          priority if (sts.n_zero) state_nxt = ST_N_CLRD;
          else if (sts.d_zero)     state_nxt = ST_N_ZD;
          else                     state_nxt = ST_N_DIV;
        end
        ST_N_CLRD: state_nxt = ST_COMMIT;
        ST_N_ZD:   state_nxt = ST_COMMIT;
        ST_N_DIV:  state_nxt = ST_N_CHK2;
        ST_N_CHK2: state_nxt = sts.n_zero ? ST_N_CLRD : ST_G_CHK;
        ST_G_CHK:  state_nxt = sts.gb_zero ? ST_G_NG : ST_G_STEP;
        ST_G_STEP: state_nxt = ST_G_CHK;
        ST_G_NG:   state_nxt = ST_G_DG;
        ST_G_DG:   state_nxt = ST_COMMIT;
        ST_INC:    state_nxt = ST_OUT;
        ST_DEC:    state_nxt = ST_OUT;
        ST_RD:     state_nxt = ST_OUT;
        ST_COMMIT: state_nxt = ST_OUT;
        ST_OUT:    state_nxt = ST_IDLE;
        default:   state_nxt = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `MFA_ASSERT_NEXT(a_leave_idle, in_valid && in_ready, state_r != ST_IDLE,
                   "command transaction accepted but sequencer stayed idle")
  `MFA_ASSERT(a_gcd_div_nonzero, !(state_r == ST_G_STEP) || !sts.gb_zero,
              "gcd step with zero divisor")

endmodule

// ===== sv/mixed_fraction_accumulator.sv =====
// channel   role    transaction payload
// in_ch     sink    operation, operand_whole, operand_numer, operand_denom
// out_ch    source  value_whole, value_numer, value_denom, status
//
// one command at a time; increment, decrement and read pass through their own state and then the output state
// set/add/multiply: each multiply or division runs on the shared shift-add
// multiplier and restoring divider; normalize takes k+3 divisions for k gcd steps,
// a check before each step and a last one, and up to four multiplies before it
// rst_n is synchronous; the accumulated value resets to zero
// a result waits in the output register; the next command is taken meanwhile
// and stalls only at its own result while out_ch is still full
module mixed_fraction_accumulator
  import mfa_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  mfa_in_if.sink    in_ch,
  mfa_out_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;
  logic ready;

  // sequencer
  mfa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(ready),
    .in_op(in_ch.operation), .sts(sts), .cmd(cmd)
  );

  assign in_ch.ready = ready;

  // arithmetic and state
  mfa_dp #(.WIDTH(WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_op(in_ch.operation), .in_whole(in_ch.operand_whole),
    .in_numer(in_ch.operand_numer), .in_denom(in_ch.operand_denom),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_whole(out_ch.value_whole), .out_numer(out_ch.value_numer),
    .out_denom(out_ch.value_denom), .out_status(out_ch.status)
  );

endmodule

// ===== verif/mixed_fraction_accumulator_tb.sv =====
module mixed_fraction_accumulator_tb
  import mfa_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // unused codes that the block treats as read
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam longint MIN32 = -64'sd2147483648;
  localparam longint MAX32 = 64'sd2147483647;
  localparam int CYCLE_LIMIT = 12000000;
  localparam int DRAIN_CYCLES = 4000;

  typedef struct {
    logic signed [31:0] whole;
    logic signed [31:0] numer;
    logic signed [31:0] denom;
    logic [1:0]         status;
  } frac_value_t;

  logic clk;
  logic rst_n;
  mfa_in_if  in_ch();
  mfa_out_if out_ch();

  mixed_fraction_accumulator #(.WIDTH(32)) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // predicted accumulator state
  longint acc_w, acc_n, acc_d;
  bit     wrapped;
  frac_value_t expected_values[$];
  int     fail_count;
  int     cycle_count;
  int     hold_off_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic longint wrap32(longint v);
    return longint'($signed(v[31:0]));
  endfunction

  task automatic frac_add(input longint x, input longint y, output longint r);
    r = wrap32(x + y);
    if ((x < 0) == (y < 0) && (r < 0) != (x < 0)) wrapped = 1'b1;
  endtask

  task automatic frac_mul(input longint x, input longint y, output longint r);
    longint p;
    p = x * y;
    r = wrap32(p);
    if (r != p) wrapped = 1'b1;
  endtask

  task automatic frac_div(input longint x, input longint y, output longint q,
                          output longint rem);
    if (x == MIN32 && y == -1) begin
      wrapped = 1'b1;
      rem = 0;
      q = MIN32;
    end else begin
      rem = x % y;
      q = x / y;
    end
  endtask

  task automatic frac_gcd(input longint x, input longint y, output longint g);
    longint q, r;
    while (y != 0) begin
      frac_div(x, y, q, r);
      x = y;
      y = r;
    end
    g = x;
  endtask

  // carry into whole part, reduce, clear empty fraction
  task automatic frac_normalize(inout longint w, inout longint n, inout longint d,
                                output bit zero_den);
    longint q, r, g, dm, t;
    zero_den = 1'b0;
    if (n == 0) begin
      d = 0;
    end else if (d == 0) begin
      zero_den = 1'b1;
    end else begin
      frac_div(n, d, q, r);
      frac_add(w, q, t);
      w = t;
      n = r;
      if (n == 0) begin
        d = 0;
      end else begin
        frac_gcd(d, n, g);
        frac_div(n, g, t, dm);
        n = t;
        frac_div(d, g, t, dm);
        d = t;
      end
    end
  endtask

  // expected value after one command
  task automatic predict_fraction(input logic [2:0] op, input logic signed [31:0] fw,
                                  input logic signed [31:0] fn,
                                  input logic signed [31:0] fd);
    longint x, y, z, w, n, d, n1, d1, n2, d2, t1, t2;
    bit zd;
    frac_value_t res;
    x = fw;
    y = fn;
    z = fd;
    wrapped = 1'b0;
    zd = 1'b0;
    case (op)
      OP_SET: begin
        acc_w = x;
        acc_n = y;
        acc_d = z;
        frac_normalize(acc_w, acc_n, acc_d, zd);
      end
      OP_ADD: begin
        frac_add(acc_w, x, w);
        if (acc_n == 0) begin
          n = y;
          d = z;
        end else if (y == 0) begin
          n = acc_n;
          d = acc_d;
        end else begin
          frac_mul(acc_n, z, t1);
          frac_mul(acc_d, y, t2);
          frac_add(t1, t2, n);
          frac_mul(acc_d, z, d);
        end
        frac_normalize(w, n, d, zd);
        acc_w = w;
        acc_n = n;
        acc_d = d;
      end
      OP_MUL: begin
        if (acc_n == 0) begin
          n1 = acc_w;
          d1 = 1;
        end else begin
          frac_mul(acc_w, acc_d, t1);
          frac_add(t1, acc_n, n1);
          d1 = acc_d;
        end
        if (y == 0) begin
          n2 = x;
          d2 = 1;
        end else begin
          frac_mul(x, z, t1);
          frac_add(t1, y, n2);
          d2 = z;
        end
        w = 0;
        frac_mul(n1, n2, n);
        frac_mul(d1, d2, d);
        frac_normalize(w, n, d, zd);
        acc_w = w;
        acc_n = n;
        acc_d = d;
      end
      OP_INC: begin
        frac_add(acc_w, 1, t1);
        acc_w = t1;
      end
      OP_DEC: begin
        frac_add(acc_w, -1, t1);
        acc_w = t1;
      end
      default: zd = (acc_n != 0 && acc_d == 0);
    endcase
    res.whole = acc_w[31:0];
    res.numer = acc_n[31:0];
    res.denom = acc_d[31:0];
    res.status = zd ? ST_ZERO_DEN : (wrapped ? ST_OVERFLOW : ST_OK);
    expected_values.push_back(res);
  endtask

  // one command transaction; valid stays high when the next gap is zero
  task automatic send_command(input logic [2:0] op, input logic signed [31:0] fw,
                              input logic signed [31:0] fn,
                              input logic signed [31:0] fd);
    int gap;
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= op;
    in_ch.operand_whole <= fw;
    in_ch.operand_numer <= fn;
    in_ch.operand_denom <= fd;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
    predict_fraction(op, fw, fn, fd);
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic stop_input();
    in_ch.valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_operand();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return $signed($urandom_range(0, 40)) - 20;
    if (sel < 85) return $signed($urandom());
    case ($urandom_range(0, 3))
      0: return MIN32[31:0];
      1: return MAX32[31:0];
      2: return -32'sd1;
      default: return 32'sd0;
    endcase
  endfunction

  // result checker
  initial begin
    frac_value_t got, exp_v;
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = hold_off_cycles > 0 ? hold_off_cycles : $urandom_range(0, 4);
      hold_off_cycles = 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(negedge clk); while (!out_ch.valid);
      got.whole = out_ch.value_whole;
      got.numer = out_ch.value_numer;
      got.denom = out_ch.value_denom;
      got.status = out_ch.status;
      @(posedge clk);
      if (expected_values.size() == 0) begin
        $error("result transaction with nothing expected");
        fail_count++;
      end else begin
        exp_v = expected_values.pop_front();
        if (got.whole !== exp_v.whole) begin
          $error("value_whole expected %0d got %0d", exp_v.whole, got.whole);
          fail_count++;
        end
        if (got.numer !== exp_v.numer) begin
          $error("value_numer expected %0d got %0d", exp_v.numer, got.numer);
          fail_count++;
        end
        if (got.denom !== exp_v.denom) begin
          $error("value_denom expected %0d got %0d", exp_v.denom, got.denom);
          fail_count++;
        end
        if (got.status !== exp_v.status) begin
          $error("status expected %0d got %0d", exp_v.status, got.status);
          fail_count++;
        end
      end
    end
  end

  // extremes, every operation and the fault cases
  task automatic test_directed();
    send_command(OP_READ, 0, 0, 0);
    send_command(OP_SET, 3, 7, 2);
    send_command(OP_SET, -3, -7, 2);
    send_command(OP_SET, 1, 6, -4);
    send_command(OP_SET, 5, 0, 9);
    send_command(OP_SET, 2, 5, 0);
    send_command(OP_READ, 0, 0, 0);
    send_command(OP_SPARE6, MIN32[31:0], MAX32[31:0], -1);
    send_command(OP_ADD, 1, 1, 3);
    send_command(OP_SET, 0, MIN32[31:0], -1);
    send_command(OP_SET, MAX32[31:0], 3, 2);
    send_command(OP_INC, 0, 0, 0);
    send_command(OP_DEC, -1, -1, -1);
    send_command(OP_SET, 1, 1, 2);
    send_command(OP_ADD, 2, 1, 3);
    send_command(OP_ADD, -1, 0, 5);
    send_command(OP_SET, 4, 0, 0);
    send_command(OP_ADD, 1, 2, 3);
    send_command(OP_MUL, 2, 1, 4);
    send_command(OP_MUL, 3, 0, 7);
    send_command(OP_MUL, MAX32[31:0], MAX32[31:0], MIN32[31:0]);
    send_command(OP_SPARE7, 0, 0, 0);
    send_command(OP_SET, MIN32[31:0], MIN32[31:0], MAX32[31:0]);
    send_command(OP_DEC, 0, 0, 0);
  endtask

  // random commands, restarted from small values now and then
  task automatic test_random(input int count);
    int sel;
    logic [2:0] op;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      if (sel < 15) op = OP_SET;
      else if (sel < 40) op = OP_ADD;
      else if (sel < 58) op = OP_MUL;
      else if (sel < 68) op = OP_INC;
      else if (sel < 78) op = OP_DEC;
      else if (sel < 90) op = OP_READ;
      else op = sel[0] ? OP_SPARE6 : OP_SPARE7;
      send_command(op, rand_operand(), rand_operand(), rand_operand());
    end
  endtask

  // receiver holds off while commands keep coming
  task automatic test_backpressure();
    hold_off_cycles = 3000;
    repeat (12) send_command(OP_ADD, rand_operand(), rand_operand(), rand_operand());
  endtask

  // sender pauses until every result is back
  task automatic test_drain_pause();
    stop_input();
    wait (expected_values.size() == 0);
    @(posedge clk);
    test_random(40);
  endtask

  initial begin
    fail_count = 0;
    cycle_count = 0;
    hold_off_cycles = 0;
    acc_w = 0;
    acc_n = 0;
    acc_d = 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= OP_READ;
    in_ch.operand_whole <= '0;
    in_ch.operand_numer <= '0;
    in_ch.operand_denom <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(800);
    test_drain_pause();
    test_random(780);
    stop_input();
    wait (expected_values.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_values.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/mfa_pkg.sv
sv/mfa_if.sv
sv/mfa_mul.sv
sv/mfa_div.sv
sv/mfa_dp.sv
sv/mfa_ctrl.sv
sv/mixed_fraction_accumulator.sv
verif/mixed_fraction_accumulator_tb.sv
